@@ hw/rtl/utf8d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared codes and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;
  localparam int unsigned StWidth  = 3;

  typedef logic [StWidth-1:0]  status_t;
  typedef logic [LenWidth-1:0] len_t;
  typedef logic [CpWidth-1:0]  cp_t;

  localparam status_t StOk        = 3'd0;
  localparam status_t StTruncated = 3'd1;
  localparam status_t StLongLead  = 3'd2;
  localparam status_t StBadLead   = 3'd3;
  localparam status_t StBadCont   = 3'd4;

  localparam len_t Len1 = 3'd1;
  localparam len_t Len2 = 3'd2;
  localparam len_t Len3 = 3'd3;
  localparam len_t Len4 = 3'd4;
  localparam len_t Len5 = 3'd5;
  localparam len_t Len6 = 3'd6;

  // one result item before packing
  typedef struct packed {
    cp_t     code_point;
    status_t status;
    len_t    seq_len;
    logic    eos;
  } result_t;

endpackage : utf8d_pkg
`default_nettype wire

@@ hw/rtl/utf8_code_point_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_unit
// Byte-serial UTF-8 decoder: one result per completed or failed sequence.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes into the input register, then is decoded into
//   the result register.
// Throughput: one byte per cycle while out_tready does not hold the result,
//   set by the combinational decode and the sequence state update in between.
// Reset: rst_n synchronous active low; clears valid flags and decoder state.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] sequence_length
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast   // end_of_string
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // decoder state
  utf8d_pkg::len_t exp_len_r, exp_len_nxt;
  utf8d_pkg::len_t seen_r, seen_nxt;
  utf8d_pkg::cp_t  acc_r, acc_nxt;
  logic            lead_bad_r, lead_bad_nxt;
  logic            cont_bad_r, cont_bad_nxt;
  logic            skip_r, skip_nxt;

  // result register
  logic                out_valid_r;
  utf8d_pkg::result_t  res_r;
  utf8d_pkg::result_t  res_nxt;
  logic                emit;

  logic advance;
  logic process;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance || !s1_valid_r;
  assign process   = advance && s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_comb begin
    logic [7:0]      b;
    logic            last;
    utf8d_pkg::len_t seen_inc;
    utf8d_pkg::cp_t  acc_upd;
    utf8d_pkg::len_t lead_len;
    utf8d_pkg::cp_t  lead_init;
    logic            lead_long;
    logic            lead_ok;
    logic            cb;

    b    = s1_byte_r;
    last = s1_last_r;

    exp_len_nxt  = exp_len_r;
    seen_nxt     = seen_r;
    acc_nxt      = acc_r;
    lead_bad_nxt = lead_bad_r;
    cont_bad_nxt = cont_bad_r;
    skip_nxt     = skip_r;

    emit               = 1'b0;
    res_nxt.code_point = '0;
    res_nxt.status     = utf8d_pkg::StOk;
    res_nxt.seq_len    = utf8d_pkg::Len1;
    res_nxt.eos        = last;

    lead_len  = utf8d_pkg::Len1;
    lead_init = '0;
    lead_long = 1'b0;
    lead_ok   = 1'b1;
    priority if ((b & 8'hE0) == 8'hC0) begin
      lead_len  = utf8d_pkg::Len2;
      lead_init = {16'd0, b[4:0]};
    end else if ((b & 8'hF0) == 8'hE0) begin
      lead_len  = utf8d_pkg::Len3;
      lead_init = {17'd0, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      lead_len  = utf8d_pkg::Len4;
      lead_init = {18'd0, b[2:0]};
    end else if ((b & 8'hFC) == 8'hF8) begin
      lead_len  = utf8d_pkg::Len5;
      lead_long = 1'b1;
    end else if ((b & 8'hFE) == 8'hFC) begin
      lead_len  = utf8d_pkg::Len6;
      lead_long = 1'b1;
    end else begin
      lead_ok = 1'b0;
    end

    seen_inc = seen_r + utf8d_pkg::Len1;
    cb       = cont_bad_r;
    acc_upd  = acc_r;
    if (!lead_bad_r && !cont_bad_r) begin
      if ((b & 8'hC0) != 8'h80) begin
        cb = 1'b1;
      end else begin
        acc_upd = {acc_r[14:0], b[5:0]};
      end
    end

    if (skip_r) begin
      if (last) begin
        skip_nxt = 1'b0;
      end
    end else if (exp_len_r == '0) begin
      if (b <= 8'h7F) begin
        emit               = 1'b1;
        res_nxt.code_point = {13'd0, b};
      end else if (!lead_ok) begin
        // stray continuation or 0xfe/0xff
        emit           = 1'b1;
        res_nxt.status = utf8d_pkg::StBadLead;
        skip_nxt       = !last;
      end else if (last) begin
        emit           = 1'b1;
        res_nxt.status = utf8d_pkg::StTruncated;
        res_nxt.seq_len = lead_len;
      end else begin
        exp_len_nxt  = lead_len;
        seen_nxt     = utf8d_pkg::Len1;
        acc_nxt      = lead_init;
        lead_bad_nxt = lead_long;
        cont_bad_nxt = 1'b0;
      end
    end else begin
      seen_nxt     = seen_inc;
      acc_nxt      = acc_upd;
      cont_bad_nxt = cb;
      if (seen_inc >= exp_len_r) begin
        emit            = 1'b1;
        res_nxt.seq_len = exp_len_r;
        priority if (lead_bad_r) begin
          res_nxt.status = utf8d_pkg::StLongLead;
        end else if (cb) begin
          res_nxt.status = utf8d_pkg::StBadCont;
        end else begin
          res_nxt.code_point = acc_upd;
        end
        skip_nxt = (lead_bad_r || cb) && !last;
      end else if (last) begin
        emit            = 1'b1;
        res_nxt.status  = utf8d_pkg::StTruncated;
        res_nxt.seq_len = exp_len_r;
      end
      if (emit) begin
        // sequence closes
        exp_len_nxt  = '0;
        seen_nxt     = '0;
        acc_nxt      = '0;
        lead_bad_nxt = 1'b0;
        cont_bad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= '0;
      seen_r      <= '0;
      acc_r       <= '0;
      lead_bad_r  <= 1'b0;
      cont_bad_r  <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= process && emit;
      if (process) begin
        exp_len_r  <= exp_len_nxt;
        seen_r     <= seen_nxt;
        acc_r      <= acc_nxt;
        lead_bad_r <= lead_bad_nxt;
        cont_bad_r <= cont_bad_nxt;
        skip_r     <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.seq_len, res_r.code_point};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.eos;

endmodule : utf8_code_point_decoder_unit
`default_nettype wire
